// ===== hw/rtl/temperature_change_reporter_macros.svh =====
// Assertion macros for the temperature change reporter.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef TEMPERATURE_CHANGE_REPORTER_MACROS_SVH
`define TEMPERATURE_CHANGE_REPORTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCR_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

// ===== hw/rtl/tcr_pkg.sv =====
// Package for the temperature change reporter: event codes, register indexes,
// reset values and payload types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

	typedef logic [1:0]         event_kind_t;
	typedef logic signed [7:0]  degrees_t;
	typedef logic signed [15:0] sample_t;
	typedef logic [1:0]         reg_index_t;
	typedef logic [15:0]        period_t;
	typedef logic [7:0]         delta_t;

	localparam event_kind_t EVT_NONE      = 2'd0;
	localparam event_kind_t EVT_IMMEDIATE = 2'd1;
	localparam event_kind_t EVT_SYNC      = 2'd2;

	localparam reg_index_t REG_READ_PERIOD   = 2'd0;
	localparam reg_index_t REG_REPORT_PERIOD = 2'd1;
	localparam reg_index_t REG_DELTA_LIMIT   = 2'd2;

	localparam period_t READ_PERIOD_RST   = 16'd1;
	localparam period_t REPORT_PERIOD_RST = 16'd60;
	localparam delta_t  DELTA_LIMIT_RST   = 8'd5;

	// Largest Q8.8 sample kept before rounding: 127.0 degrees.
	localparam sample_t SAMPLE_CLAMP_MAX = 16'sd32512;

endpackage

`default_nettype wire

// ===== hw/rtl/temperature_change_reporter.sv =====
// Temperature change reporter top level: countdowns, threshold compare, result register.
// Depends on tcr_pkg, tcr_round and temperature_change_reporter_macros.svh.
// An accepted request's result is in the output register from the next cycle on.
// Throughput: one request per cycle while out_ready is high; the output register frees in the cycle it is taken.
// Reset: arst_n clears all control state asynchronously; registers return to
// read period 1, report period 60, delta limit 5, latest degrees and threshold 0.
`timescale 1ns / 1ps
`default_nettype none

module temperature_change_reporter #(
	parameter int COUNT_WIDTH = 16
) (
	input  var logic                clk,
	input  var logic                arst_n,
	input  var logic                cfg_we,
	input  var tcr_pkg::reg_index_t cfg_index,
	input  var logic [15:0]         cfg_data,
	input  var logic                in_valid,
	output var logic                in_ready,
	input  var tcr_pkg::sample_t    sample_q8,
	output var logic                out_valid,
	input  var logic                out_ready,
	output var tcr_pkg::event_kind_t event_kind,
	output var tcr_pkg::degrees_t   current_degrees
);
	import tcr_pkg::*;
	`include "temperature_change_reporter_macros.svh"

	localparam logic [31:0] READ_RST_EXT   = {16'd0, READ_PERIOD_RST};
	localparam logic [31:0] REPORT_RST_EXT = {16'd0, REPORT_PERIOD_RST};

	period_t read_period_q;
	period_t report_period_q;
	delta_t  delta_limit_q;

	logic [COUNT_WIDTH-1:0] read_count_q;
	logic [COUNT_WIDTH-1:0] report_count_q;
	degrees_t               last_reported_q;
	degrees_t               latest_q;

	logic                   out_valid_q;
	event_kind_t            event_kind_q;
	degrees_t               current_degrees_q;

	logic [31:0]            read_ext;
	logic [31:0]            report_ext;
	logic [COUNT_WIDTH-1:0] read_reload;
	logic [COUNT_WIDTH-1:0] report_reload;
	logic [COUNT_WIDTH-1:0] read_dec;
	logic [COUNT_WIDTH-1:0] report_dec;
	logic [COUNT_WIDTH-1:0] read_next;
	logic [COUNT_WIDTH-1:0] report_next;
	logic [COUNT_WIDTH-1:0] report_mid;
	degrees_t               rounded;
	degrees_t               latest_next;
	degrees_t               last_next;
	logic signed [8:0]      diff;
	logic [8:0]             diff_abs;
	logic                   read_now;
	logic                   immediate;
	event_kind_t            kind_next;
	logic                   accept;

	tcr_round u_round (
		.sample_q8 (sample_q8),
		.degrees   (rounded)
	);

	assign in_ready        = !out_valid_q || out_ready;
	assign accept          = in_valid && in_ready;
	assign out_valid       = out_valid_q;
	assign event_kind      = event_kind_q;
	assign current_degrees = current_degrees_q;

	always_comb begin
		read_ext      = {16'd0, read_period_q};
		report_ext    = {16'd0, report_period_q};
		read_reload   = read_ext[COUNT_WIDTH-1:0];
		report_reload = report_ext[COUNT_WIDTH-1:0];

		read_dec   = (read_count_q != '0) ? read_count_q - 1'b1 : read_count_q;
		report_dec = (report_count_q != '0) ? report_count_q - 1'b1 : report_count_q;
		read_now   = (read_dec == '0);

		diff     = {rounded[7], rounded} - {last_reported_q[7], last_reported_q};
		diff_abs = diff[8] ? 9'(-diff) : 9'(diff);

		immediate   = read_now && (diff_abs >= {1'b0, delta_limit_q});
		latest_next = read_now ? rounded : latest_q;
		last_next   = immediate ? rounded : last_reported_q;
		read_next   = read_now ? read_reload : read_dec;
		report_mid  = immediate ? report_reload : report_dec;
		kind_next   = immediate ? EVT_IMMEDIATE : EVT_NONE;
		report_next = report_mid;
		if (report_mid == '0) begin
			report_next = report_reload;
			if (!immediate) begin
				kind_next = EVT_SYNC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_period_q   <= READ_PERIOD_RST;
			report_period_q <= REPORT_PERIOD_RST;
			delta_limit_q   <= DELTA_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_READ_PERIOD:   read_period_q   <= cfg_data;
				REG_REPORT_PERIOD: report_period_q <= cfg_data;
				REG_DELTA_LIMIT:   delta_limit_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_count_q    <= READ_RST_EXT[COUNT_WIDTH-1:0];
			report_count_q  <= REPORT_RST_EXT[COUNT_WIDTH-1:0];
			last_reported_q <= '0;
			latest_q        <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				read_count_q    <= read_next;
				report_count_q  <= report_next;
				last_reported_q <= last_next;
				latest_q        <= latest_next;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			event_kind_q      <= kind_next;
			current_degrees_q <= latest_next;
		end
	end

	`TCR_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, out_valid_q,
		"accepted request left no result")
	`TCR_ASSERT_IMPLY(a_kind_legal, clk, arst_n, out_valid_q, event_kind_q != 2'd3,
		"illegal event kind in output register")
	`TCR_ASSERT_NEXT(a_immediate_updates, clk, arst_n, accept && immediate,
		(last_reported_q == latest_q) && (event_kind_q == EVT_IMMEDIATE),
		"immediate event did not move the threshold")
	`TCR_ASSERT_NEXT(a_read_reload, clk, arst_n, accept && read_now,
		read_count_q == $past(read_reload), "read countdown not reloaded")

endmodule

`default_nettype wire

// ===== hw/rtl/tcr_round.sv =====
// Clamp a signed Q8.8 sample to at most 127.0 and round half up to degrees.
// Depends on tcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcr_round (
	input  var tcr_pkg::sample_t  sample_q8,
	output var tcr_pkg::degrees_t degrees
);
	import tcr_pkg::*;

	sample_t           clamped;
	logic signed [16:0] biased;

	always_comb begin
		clamped = (sample_q8 > SAMPLE_CLAMP_MAX) ? SAMPLE_CLAMP_MAX : sample_q8;
		biased  = {clamped[15], clamped} + 17'sd128;
		degrees = biased[15:8];
	end

endmodule

`default_nettype wire
